// File: design/chg_pkg.sv
package chg_pkg;

  localparam int unsigned SAMPLES       = 64;
  localparam int unsigned MAX_OBSTACLES = 16;
  localparam int unsigned STAGES        = 32;

  localparam int unsigned ROOT_W  = 33;  // bits of the distance
  localparam int unsigned SQ_W    = 66;  // bits of dx^2 + dy^2
  localparam int unsigned REM_W   = 36;  // partial remainder of the root
  localparam int unsigned NUM_W   = 48;  // dividend / shifted divisor
  localparam int unsigned Q_W     = 15;  // normal magnitude, up to 2^14
  localparam int unsigned RTOT_W  = 25;
  localparam int unsigned MARGIN_RESET = 66;

  typedef enum logic {
    CFG_DISC_RADIUS = 1'b0,
    CFG_FEAS_MARGIN = 1'b1
  } cfg_idx_e;

  // fields that ride along with an item through the whole pipe
  typedef struct packed {
    logic [4:0]        stage;
    logic [9:0]        cidx;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [RTOT_W-1:0] rtot;
    logic              neg_x;
    logic              neg_y;
    logic              degen;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] ax;
    logic [ROOT_W-1:0] ay;
    logic [SQ_W-1:0]   rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    side_t             side;
    logic [ROOT_W-1:0] span;
    logic [NUM_W-1:0]  dsh;
    logic [NUM_W-1:0]  remx;
    logic [NUM_W-1:0]  remy;
    logic [Q_W-1:0]    qx;
    logic [Q_W-1:0]    qy;
  } div_t;

endpackage

// File: design/chg_sqrt_step.sv
module chg_sqrt_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  chg_pkg::sqrt_t data_i,
  output logic           valid_o,
  output chg_pkg::sqrt_t data_o
);
  import chg_pkg::*;

  logic             valid_q;
  sqrt_t            data_d, data_q;
  logic [REM_W-1:0] rem_s, trial;

  // one result bit per stage, two radicand bits brought down
  always_comb begin
    data_d = data_i;
    rem_s  = {data_i.rem[REM_W-3:0], data_i.rad[SQ_W-1 -: 2]};
    trial  = {1'b0, data_i.root, 2'b01};
    data_d.rad = {data_i.rad[SQ_W-3:0], 2'b00};
    if (rem_s >= trial) begin
      data_d.rem  = rem_s - trial;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_s;
      data_d.root = {data_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: design/chg_div_step.sv
module chg_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  chg_pkg::div_t data_i,
  output logic          valid_o,
  output chg_pkg::div_t data_o
);
  import chg_pkg::*;

  logic valid_q;
  div_t data_d, data_q;
  logic bx, by;

  // restoring division, one quotient bit per stage for both lanes
  always_comb begin
    data_d = data_i;
    bx = data_i.remx >= data_i.dsh;
    by = data_i.remy >= data_i.dsh;
    if (bx) data_d.remx = data_i.remx - data_i.dsh;
    if (by) data_d.remy = data_i.remy - data_i.dsh;
    data_d.qx  = {data_i.qx[Q_W-2:0], bx};
    data_d.qy  = {data_i.qy[Q_W-2:0], by};
    data_d.dsh = {1'b0, data_i.dsh[NUM_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

// File: design/collision_halfspace_generator.sv
// pipeline: 3 front, 33 root, 1 setup, 15 divide and 3 back stages from input
// transfer to result
// throughput: one item per cycle; the whole pipe holds while a result waits stalled
// reset: all valid bits clear, disc radius 0, feasibility margin 66
// payload registers are not reset
module collision_halfspace_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  chg_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [4:0]         stage_i,
  input  logic [3:0]         obstacle_i,
  input  logic [5:0]         sample_i,
  input  logic signed [31:0] pose_x_i,
  input  logic signed [31:0] pose_y_i,
  input  logic signed [31:0] sample_x_i,
  input  logic signed [31:0] sample_y_i,
  input  logic [23:0]        obstacle_radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [4:0]         stage_out_o,
  output logic [9:0]         constraint_index_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [31:0] offset_o,
  output logic               infeasible_o,
  output logic               degenerate_o
);
  import chg_pkg::*;

  localparam int unsigned SQRT_N = ROOT_W;
  localparam int unsigned DIV_N  = Q_W;

  logic        adv;
  logic [23:0] disc_rad_q;
  logic [15:0] margin_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disc_rad_q <= '0;
      margin_q   <= 16'(MARGIN_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DISC_RADIUS: disc_rad_q <= cfg_data_i;
        CFG_FEAS_MARGIN: margin_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // front: differences, squares, sum
  logic               f1_v_q, f2_v_q, f3_v_q;
  side_t              f1_side_q, f2_side_q, f3_side_q;
  logic [ROOT_W-1:0]  f1_ax_q, f1_ay_q, f2_ax_q, f2_ay_q, f3_ax_q, f3_ay_q;
  logic [SQ_W-1:0]    f2_sqx_q, f2_sqy_q, f3_sq_q;
  logic signed [32:0] dx_d, dy_d;
  side_t              side_d;

  always_comb begin
    dx_d = 33'(sample_x_i) - 33'(pose_x_i);
    dy_d = 33'(sample_y_i) - 33'(pose_y_i);
    side_d.stage = stage_i;
    side_d.cidx  = 10'(10'(obstacle_i) * 10'(SAMPLES) + 10'(sample_i));
    side_d.sx    = sample_x_i;
    side_d.sy    = sample_y_i;
    side_d.rtot  = RTOT_W'(obstacle_radius_i) + RTOT_W'(disc_rad_q);
    side_d.neg_x = dx_d[32];
    side_d.neg_y = dy_d[32];
    side_d.degen = (dx_d == '0) && (dy_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
    end else if (adv) begin
      f1_v_q <= in_valid_i;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_side_q <= side_d;
      f1_ax_q   <= dx_d[32] ? ROOT_W'(-dx_d) : ROOT_W'(dx_d);
      f1_ay_q   <= dy_d[32] ? ROOT_W'(-dy_d) : ROOT_W'(dy_d);
      f2_side_q <= f1_side_q;
      f2_ax_q   <= f1_ax_q;
      f2_ay_q   <= f1_ay_q;
      f2_sqx_q  <= SQ_W'(f1_ax_q) * SQ_W'(f1_ax_q);
      f2_sqy_q  <= SQ_W'(f1_ay_q) * SQ_W'(f1_ay_q);
      f3_side_q <= f2_side_q;
      f3_ax_q   <= f2_ax_q;
      f3_ay_q   <= f2_ay_q;
      f3_sq_q   <= f2_sqx_q + f2_sqy_q;
    end
  end

  // square root, one bit per stage
  logic  sq_v [SQRT_N+1];
  sqrt_t sq_d [SQRT_N+1];

  assign sq_v[0] = f3_v_q;
  assign sq_d[0] = '{side: f3_side_q, ax: f3_ax_q, ay: f3_ay_q, rad: f3_sq_q,
                     rem: '0, root: '0};

  for (genvar i = 0; i < SQRT_N; i++) begin : g_sqrt
    chg_sqrt_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (sq_v[i]),
      .data_i  (sq_d[i]),
      .valid_o (sq_v[i+1]),
      .data_o  (sq_d[i+1])
    );
  end

  // divide setup: dividend = a*2^14 + dist/2, divisor = dist*2^14
  logic  ds_v_q;
  div_t  ds_q;
  sqrt_t sq_last;

  assign sq_last = sq_d[SQRT_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_v_q <= 1'b0;
    end else if (adv) begin
      ds_v_q <= sq_v[SQRT_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ds_q.side <= sq_last.side;
      ds_q.span <= sq_last.root;
      ds_q.dsh  <= NUM_W'({sq_last.root, 14'b0});
      ds_q.remx <= NUM_W'({sq_last.ax, 14'b0}) + NUM_W'(sq_last.root[ROOT_W-1:1]);
      ds_q.remy <= NUM_W'({sq_last.ay, 14'b0}) + NUM_W'(sq_last.root[ROOT_W-1:1]);
      ds_q.qx   <= '0;
      ds_q.qy   <= '0;
    end
  end

  logic dv_v [DIV_N+1];
  div_t dv_d [DIV_N+1];

  assign dv_v[0] = ds_v_q;
  assign dv_d[0] = ds_q;

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    chg_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (dv_v[j]),
      .data_i  (dv_d[j]),
      .valid_o (dv_v[j+1]),
      .data_o  (dv_d[j+1])
    );
  end

  // back: signed normals, products, offset and flags
  div_t               dv_last;
  logic               e1_v_q, e2_v_q, e3_v_q;
  side_t              e1_side_q, e2_side_q;
  logic [ROOT_W-1:0]  e1_dist_q, e2_dist_q;
  logic signed [15:0] e1_nx_q, e1_ny_q, e2_nx_q, e2_ny_q;
  logic signed [47:0] e2_px_q, e2_py_q;
  logic [Q_W-1:0]     qx_c, qy_c;
  logic signed [48:0] acc;
  logic signed [34:0] acc_sh;
  logic signed [35:0] b_full;
  logic signed [26:0] thr;
  logic signed [31:0] offset_d;
  logic               infeas_d;

  assign dv_last = dv_d[DIV_N];

  always_comb begin
    qx_c = (dv_last.qx > Q_W'(16384)) ? Q_W'(16384) : dv_last.qx;
    qy_c = (dv_last.qy > Q_W'(16384)) ? Q_W'(16384) : dv_last.qy;
    acc    = 49'(e2_px_q) + 49'(e2_py_q) + 49'sd8192;
    acc_sh = 35'(acc >>> 14);
    b_full = 36'(acc_sh) - 36'(signed'({1'b0, e2_side_q.rtot}));
    if (b_full > 36'sd2147483647) begin
      offset_d = 32'sh7fffffff;
    end else if (b_full < -36'sd2147483648) begin
      offset_d = 32'sh80000000;
    end else begin
      offset_d = 32'(b_full);
    end
    thr = 27'(signed'({1'b0, e2_side_q.rtot})) - 27'(signed'({1'b0, margin_q}));
    infeas_d = (thr > 27'sd0) && ({1'b0, e2_dist_q} < 34'(thr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
    end else if (adv) begin
      e1_v_q <= dv_v[DIV_N];
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e1_side_q <= dv_last.side;
      e1_dist_q <= dv_last.span;
      if (dv_last.side.degen) begin
        e1_nx_q <= '0;
        e1_ny_q <= '0;
      end else begin
        e1_nx_q <= dv_last.side.neg_x ? -16'(qx_c) : 16'(qx_c);
        e1_ny_q <= dv_last.side.neg_y ? -16'(qy_c) : 16'(qy_c);
      end
      e2_side_q <= e1_side_q;
      e2_dist_q <= e1_dist_q;
      e2_nx_q   <= e1_nx_q;
      e2_ny_q   <= e1_ny_q;
      e2_px_q   <= 48'(e1_nx_q) * 48'(e1_side_q.sx);
      e2_py_q   <= 48'(e1_ny_q) * 48'(e1_side_q.sy);
      stage_out_o        <= e2_side_q.stage;
      constraint_index_o <= e2_side_q.cidx;
      normal_x_o         <= e2_nx_q;
      normal_y_o         <= e2_ny_q;
      offset_o           <= offset_d;
      infeasible_o       <= infeas_d;
      degenerate_o       <= e2_side_q.degen;
    end
  end

  assign adv         = !(e3_v_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = e3_v_q;
endmodule
